>>> src/pse_pkg.sv
`default_nettype none

package pse_pkg;

  localparam int LETTER_COUNT = 26;
  localparam logic [7:0] LETTER_BASE = 8'd65;
  localparam int OTHER_OP_VALUE = 7;

  // Operator characters
  localparam logic [7:0] SYM_ADD    = 8'h2B;  // +
  localparam logic [7:0] SYM_SUB    = 8'h2D;  // -
  localparam logic [7:0] SYM_MUL    = 8'h2A;  // *
  localparam logic [7:0] SYM_DIV    = 8'h2F;  // /
  localparam logic [7:0] SYM_XOR    = 8'h5E;  // ^
  localparam logic [7:0] SYM_DOLLAR = 8'h24;  // $
  localparam logic [7:0] SYM_PAREN  = 8'h28;  // (
  localparam logic [7:0] SYM_HASH   = 8'h23;  // #

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_UNDER   = 3'd1,
    ST_OVER    = 3'd2,
    ST_DIVZERO = 3'd3,
    ST_BADOPND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CL_ADD    = 3'd0,
    CL_SUB    = 3'd1,
    CL_MUL    = 3'd2,
    CL_DIV    = 3'd3,
    CL_XOR    = 3'd4,
    CL_SEVEN  = 3'd5,
    CL_LETTER = 3'd6,
    CL_BAD    = 3'd7
  } sym_class_t;

  function automatic sym_class_t classify(input logic [7:0] sym);
    sym_class_t c;
    c = CL_BAD;
    unique case (sym)
      SYM_ADD: c = CL_ADD;
      SYM_SUB: c = CL_SUB;
      SYM_MUL: c = CL_MUL;
      SYM_DIV: c = CL_DIV;
      SYM_XOR: c = CL_XOR;
      SYM_DOLLAR, SYM_PAREN, SYM_HASH: c = CL_SEVEN;
      default: begin
        if (sym >= LETTER_BASE && sym < LETTER_BASE + 8'(LETTER_COUNT)) c = CL_LETTER;
        else c = CL_BAD;
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> src/postfix_stack_evaluator_unit.sv
`default_nettype none

// Postfix expression evaluator over the variables A..Z. Each input request is
// either a load (tuser = 0: store load_value into variable letter_index) or one
// ASCII symbol of the expression (tuser = 1). A letter pushes the variable, an
// operator + - * / ^ pops two values and pushes the result, and $ ( # pop two
// and push 7. The symbol flagged by tlast returns one output request with the
// top of stack and the first error of the expression (0 ok, 1 underflow,
// 2 overflow, 3 divide by zero, 4 bad operand), then the stack is emptied.
// Values are VALUE_WIDTH-bit two's complement and wrap; division truncates
// toward zero and x/0 pushes 0. The top of stack lives in a register, the rest
// of the stack and the variable table in single-port-read synchronous RAMs.
// Flow per request: a load is done when accepted; a bad symbol, or an operator
// that finds fewer than two values, goes straight to the finish state; a letter
// passes through the variable read, an operator through the operand read, and
// * and / (but not a divide by zero) then through the shared one-bit-per-cycle
// shift-add / restoring-divide unit. A last symbol also waits until the output
// register is free. One request is in flight at a time; a finished result
// waits in the output register while the next one is worked. No clearing pass
// is needed after reset.
module postfix_stack_evaluator_unit
  import pse_pkg::*;
#(
  parameter int STACK_DEPTH = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input request stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // letter_index[4:0], load_value[36:5],
                                           // symbol[44:37], zero pad [47:45]
  input  wire logic        s_axis_tuser,   // op: 0 load, 1 symbol
  input  wire logic        s_axis_tlast,   // last symbol of the expression
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata    // result[31:0], status[34:32], zero pad
);

  localparam int W   = VALUE_WIDTH;
  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int CW  = $clog2(VALUE_WIDTH + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,  // take a request
    S_VAR  = 5'b00010,  // variable read returns, push it
    S_OPND = 5'b00100,  // second operand read returns, apply
    S_ITER = 5'b01000,  // multiply / divide iterations
    S_FIN  = 5'b10000   // emit result on last symbol
  } state_t;

  state_t          state;
  logic [SPW-1:0]  sp;       // values on the stack, top included
  status_t         status;   // first error of this expression
  logic [LETTER_COUNT-1:0] var_valid;
  logic [CW-1:0]   cnt;

  logic [W-1:0]    top;
  logic [W-1:0]    opa, opb, acc;
  logic            neg_q;
  sym_class_t      cls_q;
  logic            last_q;
  logic [4:0]      idx_q;
  logic [31:0]     out_result;
  status_t         out_status;

  // request fields
  logic [4:0]  in_letter;
  logic [31:0] in_load;
  logic [7:0]  in_symbol;
  logic        in_acc;
  sym_class_t  in_cls;
  logic [7:0]  in_var_ofs;
  logic [63:0] load_ext;

  assign in_letter  = s_axis_tdata[4:0];
  assign in_load    = s_axis_tdata[36:5];
  assign in_symbol  = s_axis_tdata[44:37];
  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign in_cls     = classify(in_symbol);
  assign in_var_ofs = in_symbol - LETTER_BASE;
  assign load_ext   = 64'(signed'(in_load));

  assign s_axis_tready = (state == S_IDLE);

  // stack pointer helpers
  logic [SPW-1:0] sp_m1, sp_m2;
  logic           sp_full, sp_lt2;
  assign sp_m1   = sp - SPW'(1);
  assign sp_m2   = sp - SPW'(2);
  assign sp_full = (sp == SPW'(STACK_DEPTH));
  assign sp_lt2  = (sp < SPW'(2));

  // ---------------------------------------------------------------------------
  // Stack RAM: entries below the top register
  // ---------------------------------------------------------------------------
  logic [W-1:0]  stk_mem [STACK_DEPTH];
  logic          stk_we, stk_re;
  logic [W-1:0]  stk_rd;

  // a push spills the old top under the new one
  assign stk_we = (state == S_VAR) && !sp_full && (sp != '0);
  assign stk_re = in_acc && s_axis_tuser && (in_cls != CL_LETTER) &&
                  (in_cls != CL_BAD) && !sp_lt2;

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[sp_m1[AW-1:0]] <= top;
    if (stk_re) stk_rd <= stk_mem[sp_m2[AW-1:0]];
  end

  // ---------------------------------------------------------------------------
  // Variable RAM, valid bits stand in for the reset value of zero
  // ---------------------------------------------------------------------------
  logic [W-1:0] var_mem [LETTER_COUNT];
  logic         var_we, var_re;
  logic [W-1:0] var_rd;
  logic [W-1:0] push_val;

  assign var_we   = in_acc && !s_axis_tuser && (in_letter < 5'(LETTER_COUNT));
  assign var_re   = in_acc && s_axis_tuser && (in_cls == CL_LETTER);
  assign push_val = var_valid[idx_q] ? var_rd : '0;

  always_ff @(posedge clk) begin
    if (var_we) var_mem[in_letter] <= load_ext[W-1:0];
    if (var_re) var_rd <= var_mem[in_var_ofs[4:0]];
  end

  // ---------------------------------------------------------------------------
  // Operand stage: a = second from top, b = top
  // ---------------------------------------------------------------------------
  logic [W-1:0] alu_simple;
  logic [W-1:0] a_mag, b_mag;
  logic         b_zero, go_iter;

  always_comb begin
    unique case (cls_q)
      CL_ADD:   alu_simple = stk_rd + top;
      CL_SUB:   alu_simple = stk_rd - top;
      CL_XOR:   alu_simple = stk_rd ^ top;
      CL_SEVEN: alu_simple = W'(OTHER_OP_VALUE);
      default:  alu_simple = '0;  // divide by zero, iterated ops overwrite later
    endcase
  end

  assign a_mag   = stk_rd[W-1] ? (~stk_rd + W'(1)) : stk_rd;
  assign b_mag   = top[W-1] ? (~top + W'(1)) : top;
  assign b_zero  = (top == '0);
  assign go_iter = (cls_q == CL_MUL) || ((cls_q == CL_DIV) && !b_zero);

  // one divide step: bring down next dividend bit, subtract when it fits
  logic [W:0] div_shift;
  logic [W:0] div_diff;
  logic       div_fit;
  assign div_shift = {acc, opb[W-1]};
  assign div_diff  = div_shift - {1'b0, opa};
  assign div_fit   = (div_shift >= {1'b0, opa});

  logic iter_done;
  assign iter_done = (cnt == CW'(W));

  // ---------------------------------------------------------------------------
  // Result emit
  // ---------------------------------------------------------------------------
  logic        emit;
  logic [63:0] top_ext;
  assign emit    = (state == S_FIN) && last_q && (!m_axis_tvalid || m_axis_tready);
  assign top_ext = 64'(signed'(top));

  assign m_axis_tdata = {5'b0, out_status, out_result};

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      sp            <= '0;
      status        <= ST_OK;
      var_valid     <= '0;
      cnt           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (emit) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (!s_axis_tuser) begin
              if (var_we) var_valid[in_letter] <= 1'b1;
            end else if (in_cls == CL_LETTER) begin
              state <= S_VAR;
            end else if (in_cls == CL_BAD) begin
              if (status == ST_OK) status <= ST_BADOPND;
              state <= S_FIN;
            end else if (sp_lt2) begin
              if (status == ST_OK) status <= ST_UNDER;
              state <= S_FIN;
            end else begin
              state <= S_OPND;
            end
          end
        end
        S_VAR: begin
          if (sp_full) begin
            if (status == ST_OK) status <= ST_OVER;
          end else begin
            sp <= sp + SPW'(1);
          end
          state <= S_FIN;
        end
        S_OPND: begin
          sp <= sp_m1;
          if ((cls_q == CL_DIV) && b_zero && (status == ST_OK)) status <= ST_DIVZERO;
          cnt   <= '0;
          state <= go_iter ? S_ITER : S_FIN;
        end
        S_ITER: begin
          if (iter_done) state <= S_FIN;
          else cnt <= cnt + CW'(1);
        end
        S_FIN: begin
          if (!last_q) begin
            state <= S_IDLE;
          end else if (emit) begin
            sp     <= '0;
            status <= ST_OK;
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cls_q  <= in_cls;
      last_q <= s_axis_tlast;
      idx_q  <= in_var_ofs[4:0];
    end

    if (state == S_VAR && !sp_full) top <= push_val;

    if (state == S_OPND) begin
      top <= alu_simple;
      acc <= '0;
      if (cls_q == CL_MUL) begin
        opa <= stk_rd;
        opb <= top;
      end else begin
        opa   <= b_mag;   // divisor
        opb   <= a_mag;   // dividend, becomes quotient
        neg_q <= stk_rd[W-1] ^ top[W-1];
      end
    end

    if (state == S_ITER) begin
      if (iter_done) begin
        if (cls_q == CL_MUL) top <= acc;
        else top <= neg_q ? (~opb + W'(1)) : opb;
      end else if (cls_q == CL_MUL) begin
        if (opb[0]) acc <= acc + opa;
        opa <= opa << 1;
        opb <= opb >> 1;
      end else begin
        acc <= div_fit ? div_diff[W-1:0] : div_shift[W-1:0];
        opb <= {opb[W-2:0], div_fit};
      end
    end

    if (emit) begin
      out_result <= (sp == '0) ? 32'd0 : top_ext[31:0];
      out_status <= ((sp == '0) && (status == ST_OK)) ? ST_UNDER : status;
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= SPW'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  a_emit_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == S_FIN && last_q))
    else $error("result without a last symbol");

  a_emit_clear: assert property (@(posedge clk) disable iff (rst)
    emit |=> (sp == '0) && (status == ST_OK) && (state == S_IDLE))
    else $error("expression state not cleared after result");

  a_iter_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == S_ITER) |-> (cnt <= CW'(W)))
    else $error("iteration count overrun");

  a_divzero_no_iter: assert property (@(posedge clk) disable iff (rst)
    (state == S_OPND && cls_q == CL_DIV && b_zero) |=> (state == S_FIN))
    else $error("divide by zero entered the divider");

endmodule

`default_nettype wire

>>> tb/tb_postfix_stack_evaluator_unit.sv
`default_nettype none

module tb_postfix_stack_evaluator_unit;
  import pse_pkg::*;

  localparam int STACK_DEPTH = 32;
  localparam int CALM_TAIL   = 50;   // last requests go out with no idling
  localparam int RX_HOLD_CYC = 400;  // long receiver hold-off to back up the block

  // one input request, as it travels on the slave side
  typedef struct packed {
    logic        op;          // 0 load, 1 symbol
    logic [4:0]  letter;
    logic [31:0] load_value;
    logic [7:0]  symbol;
    logic        last;
  } request_t;

  // one result: top of stack and first error of the expression
  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  status;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // letter_index[4:0], load_value[36:5], symbol[44:37], pad
  logic        s_axis_tuser = 1'b0; // op
  logic        s_axis_tlast = 1'b0; // last symbol of the expression
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // result[31:0], status[34:32], pad

  postfix_stack_evaluator_unit dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shared bookkeeping
  // ---------------------------------------------------------------------------
  request_t symbol_feed[$];       // requests still to be offered
  outcome_t awaited_results[$];   // predicted results, oldest first
  int       total_requests = 0;
  int       ignored_loads  = 0;   // loads to letters past Z, not counted as stimulus
  int       accepted_count = 0;
  int       results_seen   = 0;
  int       mismatches     = 0;
  logic     rx_hold = 1'b0;       // long receiver hold-off in progress

  // ---------------------------------------------------------------------------
  // Predictor state: variable table, value stack, first error
  // ---------------------------------------------------------------------------
  logic [31:0] var_table [LETTER_COUNT];
  logic [31:0] eval_stack[STACK_DEPTH];
  int          eval_depth = 0;
  status_t     first_error = ST_OK;

  initial begin
    for (int i = 0; i < LETTER_COUNT; i++) var_table[i] = '0;
  end

  function automatic void note_error(status_t code);
    if (first_error == ST_OK) first_error = code;
  endfunction

  function automatic void push_value(logic [31:0] v);
    if (eval_depth >= STACK_DEPTH) begin
      note_error(ST_OVER);
    end else begin
      eval_stack[eval_depth] = v;
      eval_depth++;
    end
  endfunction

  // Applies one accepted request; a last symbol queues the expected result.
  function automatic void evaluate_request(request_t rq);
    logic [31:0] a, b, r;
    logic        is_operator;
    outcome_t    res;
    if (!rq.op) begin
      // loads never produce a result, last or not; letters past Z are dropped
      if (rq.letter < LETTER_COUNT) var_table[rq.letter] = rq.load_value;
      return;
    end
    case (rq.symbol)
      SYM_ADD, SYM_SUB, SYM_MUL, SYM_DIV, SYM_XOR,
      SYM_DOLLAR, SYM_PAREN, SYM_HASH: is_operator = 1'b1;
      default: is_operator = 1'b0;
    endcase
    if (is_operator) begin
      if (eval_depth < 2) begin
        note_error(ST_UNDER);   // stack left as is
      end else begin
        b = eval_stack[eval_depth - 1];
        a = eval_stack[eval_depth - 2];
        eval_depth -= 2;
        case (rq.symbol)
          SYM_ADD: r = a + b;
          SYM_SUB: r = a - b;
          SYM_MUL: r = a * b;
          SYM_XOR: r = a ^ b;
          SYM_DIV: begin
            if (b == '0) begin
              note_error(ST_DIVZERO);
              r = '0;
            end else if (b == '1) begin
              r = -a;   // min / -1 wraps back to min
            end else begin
              r = $signed(a) / $signed(b);
            end
          end
          default: r = 32'(OTHER_OP_VALUE);
        endcase
        push_value(r);
      end
    end else if (rq.symbol >= LETTER_BASE && rq.symbol < LETTER_BASE + LETTER_COUNT) begin
      push_value(var_table[rq.symbol - LETTER_BASE]);
    end else begin
      note_error(ST_BADOPND);
    end
    if (rq.last) begin
      if (eval_depth == 0) begin
        note_error(ST_UNDER);
        res.value = '0;
      end else begin
        res.value = eval_stack[eval_depth - 1];
      end
      res.status = first_error;
      awaited_results.push_back(res);
      eval_depth  = 0;
      first_error = ST_OK;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void add_load(logic [4:0] letter, logic [31:0] v, logic last);
    request_t rq;
    rq = '{op: 1'b0, letter: letter, load_value: v, symbol: 8'($urandom), last: last};
    symbol_feed.push_back(rq);
    total_requests++;
    if (letter >= LETTER_COUNT) ignored_loads++;
  endfunction

  function automatic void add_symbol(logic [7:0] sym, logic last);
    request_t rq;
    rq = '{op: 1'b1, letter: 5'($urandom), load_value: $urandom, symbol: sym, last: last};
    symbol_feed.push_back(rq);
    total_requests++;
  endfunction

  function automatic logic [7:0] letter_char(int idx);
    return LETTER_BASE + 8'(idx);
  endfunction

  function automatic logic [7:0] random_letter();
    return letter_char($urandom_range(0, LETTER_COUNT - 1));
  endfunction

  function automatic logic [7:0] random_operator();
    case ($urandom_range(0, 7))
      0: return SYM_ADD;
      1: return SYM_SUB;
      2: return SYM_MUL;
      3: return SYM_DIV;
      4: return SYM_XOR;
      5: return SYM_DOLLAR;
      6: return SYM_PAREN;
      default: return SYM_HASH;
    endcase
  endfunction

  // corner-heavy variable values; zero makes divides by zero likely
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'hFFFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'h7FFF_FFFF;
      5: return 32'($signed($urandom_range(0, 20)) - 10);
      default: return $urandom;
    endcase
  endfunction

  // Well-formed postfix with random letters and operators; now and then one
  // symbol is swapped for a random byte to break the sequence.
  function automatic void add_expression(int operands, int max_ops, bit spoil);
    logic [7:0] chars[$];
    int         depth, left, ops;
    depth = 0;
    left  = operands;
    ops   = 0;
    while (left > 0 || (depth > 1 && ops < max_ops)) begin
      if (left > 0 && (depth < 2 || $urandom_range(0, 1) == 0)) begin
        chars.push_back(random_letter());
        depth++;
        left--;
      end else begin
        chars.push_back(random_operator());
        depth--;
        ops++;
      end
    end
    if (spoil) chars[$urandom_range(0, chars.size() - 1)] = 8'($urandom);
    for (int i = 0; i < chars.size(); i++) add_symbol(chars[i], i == chars.size() - 1);
  endfunction

  // no idling near the end of the run, and every third window runs flat out
  function automatic bit idling_allowed();
    return symbol_feed.size() >= CALM_TAIL && (($time / 2400) % 3) != 2;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers requests from symbol_feed, predicts each accepted one
  // ---------------------------------------------------------------------------
  request_t on_bus;
  int       tx_gap = 0;

  always @(posedge clk) begin : request_driver
    logic offer;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        evaluate_request(on_bus);
        accepted_count++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        offer = 1'b0;
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (symbol_feed.size() > 0) begin
          // while the receiver is held off, keep offering so the block backs up
          if (!rx_hold && idling_allowed() && $urandom_range(0, 9) == 0) begin
            tx_gap = $urandom_range(1, 16) - 1;
          end else begin
            on_bus = symbol_feed.pop_front();
            offer  = 1'b1;
            s_axis_tdata <= {3'b000, on_bus.symbol, on_bus.load_value, on_bus.letter};
            s_axis_tuser <= on_bus.op;
            s_axis_tlast <= on_bus.last;
          end
        end
        s_axis_tvalid <= offer;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random backpressure, checks each result against the oldest one
  // predicted
  // ---------------------------------------------------------------------------
  int rx_gap = 0;

  always @(posedge clk) begin : result_monitor
    outcome_t    want;
    logic [31:0] got_value;
    logic [2:0]  got_status;
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_gap = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_value  = m_axis_tdata[31:0];
        got_status = m_axis_tdata[34:32];
        results_seen++;
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result %0d status %0d, none predicted",
                     $signed(got_value), got_status);
        end else begin
          want = awaited_results.pop_front();
          if (got_value !== want.value || got_status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d mismatch: expected %0d status %0d, got %0d status %0d",
                       results_seen, $signed(want.value), want.status,
                       $signed(got_value), got_status);
          end
        end
      end
      if (rx_hold) begin
        m_axis_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        m_axis_tready <= 1'b0;
      end else if (idling_allowed() && $urandom_range(0, 7) == 0) begin
        rx_gap = $urandom_range(1, 16) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // one long receiver hold-off once results are flowing
  initial begin : receiver_holdoff
    while (results_seen < 4) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (RX_HOLD_CYC) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int iter;
    // directed: A = max, Z = min, B = -1, Y stays zero from reset
    add_load(5'd0, 32'h7FFF_FFFF, 1'b0);
    add_load(5'd25, 32'h8000_0000, 1'b0);
    add_load(5'd31, 32'hFFFF_FFFF, 1'b1);   // past Z: dropped, and a load never answers
    add_load(5'd1, 32'hFFFF_FFFF, 1'b0);
    // A Z + B *  -> (max + min) * -1 = 1
    add_symbol(letter_char(0), 1'b0);
    add_symbol(letter_char(25), 1'b0);
    add_symbol(SYM_ADD, 1'b0);
    add_symbol(letter_char(1), 1'b0);
    add_symbol(SYM_MUL, 1'b1);
    // Z B / A ^  -> min / -1 wraps to min, then xor with max
    add_symbol(letter_char(25), 1'b0);
    add_symbol(letter_char(1), 1'b0);
    add_symbol(SYM_DIV, 1'b0);
    add_symbol(letter_char(0), 1'b0);
    add_symbol(SYM_XOR, 1'b1);
    // A Y /  -> divide by zero pushes 0
    add_symbol(letter_char(0), 1'b0);
    add_symbol(letter_char(24), 1'b0);
    add_symbol(SYM_DIV, 1'b1);
    // A B - A $ B (  -> subtract wraps, then the two constant-7 operators
    add_symbol(letter_char(0), 1'b0);
    add_symbol(letter_char(1), 1'b0);
    add_symbol(SYM_SUB, 1'b0);
    add_symbol(letter_char(0), 1'b0);
    add_symbol(SYM_DOLLAR, 1'b0);
    add_symbol(letter_char(1), 1'b0);
    add_symbol(SYM_PAREN, 1'b1);
    // lone operator: underflow on an empty stack; lone bad symbol
    add_symbol(SYM_HASH, 1'b1);
    add_symbol(8'h61, 1'b1);

    // random part: mostly well-formed expressions, two deep enough to overflow
    iter = 0;
    while (total_requests - ignored_loads < 390) begin
      if (iter == 10 || iter == 40) begin
        // letters past the stack depth, then one operator on the full stack
        repeat (STACK_DEPTH + 2) add_symbol(random_letter(), 1'b0);
        add_symbol(random_operator(), 1'b1);
      end else begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3:
            add_load($urandom_range(0, 7) == 0 ? 5'($urandom_range(26, 31))
                                               : 5'($urandom_range(0, 25)),
                     pick_value(), 1'($urandom_range(0, 1)));
          4, 5: begin
            // noise: random bytes with random last
            repeat ($urandom_range(1, 4)) add_symbol(8'($urandom), 1'($urandom_range(0, 1)));
          end
          default:
            add_expression($urandom_range(1, 6), STACK_DEPTH, $urandom_range(0, 9) == 0);
        endcase
      end
      iter++;
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (accepted_count < total_requests) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(12 * 500000);
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
src/pse_pkg.sv
src/postfix_stack_evaluator_unit.sv
tb/tb_postfix_stack_evaluator_unit.sv
